@@ src/flash_ring_slot_manager_defines.svh @@
// ----------------------------------------------------------------------------
// Slot manager assertion macros
// Shared property wrappers for the ring slot manager checks.
// ----------------------------------------------------------------------------
`ifndef FLASH_RING_SLOT_MANAGER_DEFINES_SVH
`define FLASH_RING_SLOT_MANAGER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define FRSM_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define FRSM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/frsm_pkg.sv @@
// ----------------------------------------------------------------------------
// Slot manager package
// Constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none
package frsm_pkg;

	localparam int SLOTS_PER_SECTOR = 256;
	localparam int MAX_SECTORS      = 64;
	localparam int RECORD_MAX       = 8;
	localparam int ALL_SLOTS        = SLOTS_PER_SECTOR * MAX_SECTORS;
	localparam int SPS_W            = $clog2(SLOTS_PER_SECTOR);
	localparam int SLOT_W           = $clog2(ALL_SLOTS);
	localparam int CNT_W            = SLOT_W + 1;
	localparam int PEND_CAP         = 32767;

	typedef enum logic [1:0] {
		MK_FREE    = 2'd0,
		MK_PENDING = 2'd1,
		MK_SENT    = 2'd2
	} mark_t;

	typedef enum logic [1:0] {
		FN_APPEND = 2'd0,
		FN_MARK   = 2'd1,
		FN_BATCH  = 2'd2,
		FN_CLEAR  = 2'd3
	} func_t;

	typedef enum logic {
		REG_ENABLE  = 1'b0,
		REG_SECTORS = 1'b1
	} reg_idx_t;

	typedef enum logic [4:0] {
		C_NOP, C_PTR0, C_SWEEP, C_WIPE, C_LOAD, C_FAIL, C_SCAN, C_ERASE_INIT,
		C_ERASE, C_DROP, C_APPEND, C_RETIRE, C_WINIT, C_WSTEP, C_WEND, C_BADV,
		C_BMOD, C_FINISH
	} op_t;

	typedef enum logic [4:0] {
		S_SWEEP_INIT, S_SWEEP, S_WIPE, S_IDLE, S_DISPATCH, S_SCAN_RD, S_SCAN_CHK,
		S_SCAN_END, S_ERASE_INIT, S_ERASE, S_DROP, S_APPEND, S_M_RD, S_M_CHK,
		S_W_INIT, S_W_RD, S_W_CHK, S_B_TEST, S_B_CHK, S_B_ADV, S_B_MOD, S_DONE
	} state_t;

	typedef struct packed {
		op_t  op;
		logic rd_walk;
	} cmd_t;

	typedef struct packed {
		func_t func;
		logic  rej;
		logic  at_bound;
		logic  slot_ok;
		logic  scan_last;
		logic  need_erase;
		logic  sweep_last;
		logic  pend_hit;
		logic  rh_hit;
		logic  wseen_full;
		logic  b_stop;
		logic  b_pending;
		logic  ptr_high;
		logic  ofree;
	} stat_t;

endpackage
`default_nettype wire

@@ src/frsm_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module frsm_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 16384
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

@@ src/frsm_ctrl.sv @@
// ----------------------------------------------------------------------------
// Slot manager controller
// Sequences sweeps, scans, erases, walks and batches over the datapath.
// ----------------------------------------------------------------------------
`default_nettype none
module frsm_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire frsm_pkg::stat_t  st,
	output frsm_pkg::cmd_t        cmd
);

	frsm_pkg::state_t state_q, state_d;
	logic boot_q, boot_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= frsm_pkg::S_SWEEP_INIT;
			boot_q  <= 1'b1;
		end else begin
			state_q <= state_d;
			boot_q  <= boot_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		boot_d      = boot_q;
		cmd.op      = frsm_pkg::C_NOP;
		cmd.rd_walk = 1'b0;
		in_ready    = 1'b0;
		unique case (state_q)
			frsm_pkg::S_SWEEP_INIT: begin
				cmd.op  = frsm_pkg::C_PTR0;
				state_d = frsm_pkg::S_SWEEP;
			end
			frsm_pkg::S_SWEEP: begin
				cmd.op = frsm_pkg::C_SWEEP;
				if (st.sweep_last) begin
					boot_d  = 1'b0;
					state_d = boot_q ? frsm_pkg::S_IDLE : frsm_pkg::S_WIPE;
				end
			end
			frsm_pkg::S_WIPE: begin
				cmd.op  = frsm_pkg::C_WIPE;
				state_d = frsm_pkg::S_DONE;
			end
			frsm_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op  = frsm_pkg::C_LOAD;
					state_d = frsm_pkg::S_DISPATCH;
				end
			end
			frsm_pkg::S_DISPATCH: begin
				unique case (st.func)
					frsm_pkg::FN_APPEND: begin
						if (st.rej) begin
							cmd.op  = frsm_pkg::C_FAIL;
							state_d = frsm_pkg::S_DONE;
						end else begin
							state_d = st.at_bound ? frsm_pkg::S_SCAN_RD : frsm_pkg::S_APPEND;
						end
					end
					frsm_pkg::FN_MARK: begin
						if (st.slot_ok) begin
							state_d = frsm_pkg::S_M_RD;
						end else begin
							cmd.op  = frsm_pkg::C_FAIL;
							state_d = frsm_pkg::S_DONE;
						end
					end
					frsm_pkg::FN_BATCH: state_d = frsm_pkg::S_B_TEST;
					default:            state_d = frsm_pkg::S_SWEEP_INIT;
				endcase
			end
			frsm_pkg::S_SCAN_RD: state_d = frsm_pkg::S_SCAN_CHK;
			frsm_pkg::S_SCAN_CHK: begin
				cmd.op  = frsm_pkg::C_SCAN;
				state_d = st.scan_last ? frsm_pkg::S_SCAN_END : frsm_pkg::S_SCAN_RD;
			end
			frsm_pkg::S_SCAN_END: begin
				state_d = st.need_erase ? frsm_pkg::S_ERASE_INIT : frsm_pkg::S_APPEND;
			end
			frsm_pkg::S_ERASE_INIT: begin
				cmd.op  = frsm_pkg::C_ERASE_INIT;
				state_d = frsm_pkg::S_ERASE;
			end
			frsm_pkg::S_ERASE: begin
				cmd.op = frsm_pkg::C_ERASE;
				if (st.scan_last) begin
					state_d = frsm_pkg::S_DROP;
				end
			end
			frsm_pkg::S_DROP: begin
				cmd.op  = frsm_pkg::C_DROP;
				state_d = frsm_pkg::S_APPEND;
			end
			frsm_pkg::S_APPEND: begin
				cmd.op  = frsm_pkg::C_APPEND;
				state_d = frsm_pkg::S_DONE;
			end
			frsm_pkg::S_M_RD: state_d = frsm_pkg::S_M_CHK;
			frsm_pkg::S_M_CHK: begin
				if (st.pend_hit) begin
					cmd.op  = frsm_pkg::C_RETIRE;
					state_d = st.rh_hit ? frsm_pkg::S_W_INIT : frsm_pkg::S_DONE;
				end else begin
					cmd.op  = frsm_pkg::C_FAIL;
					state_d = frsm_pkg::S_DONE;
				end
			end
			frsm_pkg::S_W_INIT: begin
				cmd.op  = frsm_pkg::C_WINIT;
				state_d = frsm_pkg::S_W_RD;
			end
			frsm_pkg::S_W_RD: begin
				cmd.rd_walk = 1'b1;
				if (st.wseen_full) begin
					cmd.op  = frsm_pkg::C_WEND;
					state_d = (st.func == frsm_pkg::FN_MARK) ? frsm_pkg::S_DONE
						: frsm_pkg::S_B_ADV;
				end else begin
					state_d = frsm_pkg::S_W_CHK;
				end
			end
			frsm_pkg::S_W_CHK: begin
				cmd.op = frsm_pkg::C_WSTEP;
				if (st.pend_hit) begin
					state_d = (st.func == frsm_pkg::FN_MARK) ? frsm_pkg::S_DONE
						: frsm_pkg::S_B_ADV;
				end else begin
					state_d = frsm_pkg::S_W_RD;
				end
			end
			frsm_pkg::S_B_TEST: begin
				state_d = st.b_stop ? frsm_pkg::S_DONE : frsm_pkg::S_B_CHK;
			end
			frsm_pkg::S_B_CHK: begin
				if (st.b_pending) begin
					cmd.op  = frsm_pkg::C_RETIRE;
					state_d = st.rh_hit ? frsm_pkg::S_W_INIT : frsm_pkg::S_B_ADV;
				end else begin
					state_d = frsm_pkg::S_B_ADV;
				end
			end
			frsm_pkg::S_B_ADV: begin
				cmd.op  = frsm_pkg::C_BADV;
				state_d = frsm_pkg::S_B_MOD;
			end
			frsm_pkg::S_B_MOD: begin
				if (st.ptr_high) begin
					cmd.op = frsm_pkg::C_BMOD;
				end else begin
					state_d = frsm_pkg::S_B_TEST;
				end
			end
			frsm_pkg::S_DONE: begin
				if (st.ofree) begin
					cmd.op  = frsm_pkg::C_FINISH;
					state_d = frsm_pkg::S_IDLE;
				end
			end
			default: state_d = frsm_pkg::S_SWEEP_INIT;
		endcase
	end

endmodule
`default_nettype wire

@@ src/frsm_dp.sv @@
// ----------------------------------------------------------------------------
// Slot manager datapath
// Heads, counters, slot mark memory, configuration and result register.
// ----------------------------------------------------------------------------
`default_nettype none
module frsm_dp (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire frsm_pkg::cmd_t  cmd,
	output frsm_pkg::stat_t      st,
	input  wire logic            cfg_valid,
	input  wire logic            cfg_index,
	input  wire logic [6:0]      cfg_data,
	input  wire logic [1:0]      in_func,
	input  wire logic [frsm_pkg::SLOT_W-1:0] in_slot,
	input  wire logic [15:0]     in_bcnt,
	input  wire logic [7:0]      in_len,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output logic                 out_status,
	output logic [frsm_pkg::SLOT_W-1:0] out_written,
	output logic [8:0]           out_dropped,
	output logic [14:0]          out_pending,
	output logic [31:0]          out_lost,
	output logic [frsm_pkg::SLOT_W-1:0] out_wh,
	output logic [frsm_pkg::SLOT_W-1:0] out_rh
);

	localparam int SW = frsm_pkg::SLOT_W;
	localparam int CW = frsm_pkg::CNT_W;

	logic [SW-1:0] wh_q, rh_q;
	logic [14:0]   pend_q;
	logic [31:0]   lost_q;
	logic          en_q;
	logic [6:0]    secs_q;

	frsm_pkg::func_t func_q;
	logic [SW-1:0]  eff_q;
	logic [CW-1:0]  ptr_q, wp_q, seen_q, wseen_q;
	logic [15:0]    bcnt_q, done_q;
	logic [7:0]     len_q;
	logic [frsm_pkg::SPS_W-1:0] cnt_q;
	logic [8:0]     drop_q;
	logic [1:0]     first_q;
	logic           status_q;
	logic [SW-1:0]  written_q;

	logic [6:0]    sec_eff;
	logic [CW-1:0] total;
	logic [CW-1:0] eff_x, sect_end, wp_next, eff_next;
	logic [SW-1:0] eff_in;
	logic          ram_we;
	logic [SW-1:0] ram_waddr, ram_raddr;
	logic [1:0]    ram_wdata, ram_rdata;
	logic [32:0]   lost_sum;

	function automatic logic [CW-1:0] next_slot(input logic [CW-1:0] x,
		input logic [CW-1:0] tot);
		logic [CW-1:0] n;
		n = x + CW'(1);
		return (n == tot) ? '0 : n;
	endfunction

	always_comb begin
		if (secs_q == 7'd0) begin
			sec_eff = 7'd1;
		end else if (secs_q > 7'(frsm_pkg::MAX_SECTORS)) begin
			sec_eff = 7'(frsm_pkg::MAX_SECTORS);
		end else begin
			sec_eff = secs_q;
		end
	end

	assign total    = CW'(sec_eff) << frsm_pkg::SPS_W;
	assign eff_in   = (CW'(wh_q) < total) ? wh_q : '0;
	assign eff_x    = CW'(eff_q);
	assign sect_end = eff_x + CW'(frsm_pkg::SLOTS_PER_SECTOR);
	assign wp_next  = next_slot(wp_q, total);
	assign eff_next = next_slot(eff_x, total);
	assign lost_sum = {1'b0, lost_q} + 33'(drop_q);

	assign st.func       = func_q;
	assign st.rej        = !en_q || (len_q == 8'd0) || (len_q > 8'(frsm_pkg::RECORD_MAX));
	assign st.at_bound   = (eff_q[frsm_pkg::SPS_W-1:0] == '0);
	assign st.slot_ok    = (ptr_q < total);
	assign st.scan_last  = (cnt_q == frsm_pkg::SPS_W'(frsm_pkg::SLOTS_PER_SECTOR - 1));
	assign st.need_erase = (drop_q != 9'd0) || (first_q != frsm_pkg::MK_FREE);
	assign st.sweep_last = (ptr_q == CW'(frsm_pkg::ALL_SLOTS - 1));
	assign st.pend_hit   = (ram_rdata == frsm_pkg::MK_PENDING);
	assign st.rh_hit     = (ptr_q == CW'(rh_q));
	assign st.wseen_full = (wseen_q == total);
	assign st.b_stop     = (done_q >= bcnt_q) || (seen_q >= total);
	assign st.b_pending  = (ram_rdata == frsm_pkg::MK_PENDING) && (ptr_q < total);
	assign st.ptr_high   = (ptr_q >= total);
	assign st.ofree      = !out_valid || out_ready;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = ptr_q[SW-1:0];
		ram_wdata = frsm_pkg::MK_FREE;
		case (cmd.op)
			frsm_pkg::C_SWEEP, frsm_pkg::C_ERASE: ram_we = 1'b1;
			frsm_pkg::C_RETIRE: begin
				ram_we    = 1'b1;
				ram_wdata = frsm_pkg::MK_SENT;
			end
			frsm_pkg::C_APPEND: begin
				ram_we    = 1'b1;
				ram_waddr = eff_q;
				ram_wdata = frsm_pkg::MK_PENDING;
			end
			default: ram_we = 1'b0;
		endcase
	end

	assign ram_raddr = cmd.rd_walk ? wp_q[SW-1:0] : ptr_q[SW-1:0];

	frsm_ram #(.WIDTH(2), .DEPTH(frsm_pkg::ALL_SLOTS)) u_marks (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wh_q      <= '0;
			rh_q      <= '0;
			pend_q    <= '0;
			lost_q    <= '0;
			en_q      <= 1'b1;
			secs_q    <= 7'(frsm_pkg::MAX_SECTORS);
			out_valid <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					frsm_pkg::REG_ENABLE:  en_q   <= cfg_data[0];
					frsm_pkg::REG_SECTORS: secs_q <= cfg_data;
					default:               en_q   <= en_q;
				endcase
			end
			if (cmd.op == frsm_pkg::C_FINISH) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			case (cmd.op)
				frsm_pkg::C_WIPE: begin
					wh_q   <= '0;
					rh_q   <= '0;
					pend_q <= '0;
					lost_q <= '0;
				end
				frsm_pkg::C_DROP: begin
					if (drop_q != 9'd0) begin
						lost_q <= lost_sum[32] ? '1 : lost_sum[31:0];
						pend_q <= (pend_q >= 15'(drop_q)) ? pend_q - 15'(drop_q) : '0;
						if (CW'(rh_q) >= eff_x && CW'(rh_q) < sect_end) begin
							rh_q <= (sect_end == total) ? '0 : sect_end[SW-1:0];
						end
					end
				end
				frsm_pkg::C_APPEND: begin
					if (pend_q == '0) begin
						rh_q <= eff_q;
					end
					if (pend_q < 15'(frsm_pkg::PEND_CAP)) begin
						pend_q <= pend_q + 15'd1;
					end
					wh_q <= eff_next[SW-1:0];
				end
				frsm_pkg::C_RETIRE: begin
					if (pend_q != '0) begin
						pend_q <= pend_q - 15'd1;
					end
				end
				frsm_pkg::C_WSTEP: begin
					if (st.pend_hit) begin
						rh_q <= wp_q[SW-1:0];
					end
				end
				frsm_pkg::C_WEND: rh_q <= wp_q[SW-1:0];
				default: rh_q <= rh_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			frsm_pkg::C_LOAD: begin
				func_q    <= frsm_pkg::func_t'(in_func);
				bcnt_q    <= in_bcnt;
				len_q     <= in_len;
				eff_q     <= eff_in;
				ptr_q     <= (in_func == frsm_pkg::FN_APPEND) ? CW'(eff_in) : CW'(in_slot);
				cnt_q     <= '0;
				drop_q    <= '0;
				seen_q    <= '0;
				done_q    <= '0;
				status_q  <= 1'b0;
				written_q <= '0;
			end
			frsm_pkg::C_PTR0:  ptr_q <= '0;
			frsm_pkg::C_SWEEP: ptr_q <= ptr_q + CW'(1);
			frsm_pkg::C_FAIL:  status_q <= 1'b1;
			frsm_pkg::C_SCAN: begin
				if (st.pend_hit) begin
					drop_q <= drop_q + 9'd1;
				end
				if (cnt_q == '0) begin
					first_q <= ram_rdata;
				end
				cnt_q <= cnt_q + 1'b1;
				ptr_q <= ptr_q + CW'(1);
			end
			frsm_pkg::C_ERASE_INIT: begin
				ptr_q <= eff_x;
				cnt_q <= '0;
			end
			frsm_pkg::C_ERASE: begin
				ptr_q <= ptr_q + CW'(1);
				cnt_q <= cnt_q + 1'b1;
			end
			frsm_pkg::C_APPEND: written_q <= eff_q;
			frsm_pkg::C_RETIRE: done_q <= done_q + 16'd1;
			frsm_pkg::C_WINIT: begin
				wp_q    <= next_slot(ptr_q, total);
				wseen_q <= '0;
			end
			frsm_pkg::C_WSTEP: begin
				if (!st.pend_hit) begin
					wp_q    <= wp_next;
					wseen_q <= wseen_q + CW'(1);
				end
			end
			frsm_pkg::C_BADV: begin
				ptr_q  <= ptr_q + CW'(1);
				seen_q <= seen_q + CW'(1);
			end
			frsm_pkg::C_BMOD: ptr_q <= ptr_q - total;
			frsm_pkg::C_FINISH: begin
				out_status  <= status_q;
				out_written <= written_q;
				out_dropped <= drop_q;
				out_pending <= pend_q;
				out_lost    <= lost_q;
				out_wh      <= wh_q;
				out_rh      <= rh_q;
			end
			default: cnt_q <= cnt_q;
		endcase
	end

endmodule
`default_nettype wire

@@ src/flash_ring_slot_manager.sv @@
// ----------------------------------------------------------------------------
// Flash ring slot manager
// Tracks free, pending and sent marks of a sector-organised slot ring.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over all 16384 slot marks, one
// per cycle, and takes no request until it ends (configuration writes are
// taken at all times). It works on one request at a time; the slot mark
// memory has one read and one write port and each visited slot takes a read
// step, then a check step. An append off a sector boundary goes straight to
// its write; on a boundary it first scans the sector and, if needed, erases
// it. A mark request may add a walk of the read head to the next pending
// slot (up to one ring length). A batch visits its slots one by one plus
// any read head walks, and a start slot outside the ring is folded back by
// subtracting the ring length. A clear sweeps the whole memory again. The
// result sits in an output register so the next request is accepted while
// it waits to be taken.
`default_nettype none
`include "flash_ring_slot_manager_defines.svh"
module flash_ring_slot_manager (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// request stream
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [39:0]  s_tdata,  // slot_index[13:0], batch_count[29:14], rec_len[37:30]
	input  wire logic [1:0]   s_tuser,  // func[1:0]
	// result stream
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [103:0]      m_tdata,  // written_slot[13:0], dropped[22:14],
	                                    // pending_now[37:23], lost_now[69:38],
	                                    // write_head_now[83:70], read_head_now[97:84]
	output logic [0:0]        m_tuser,  // status[0]
	// configuration writes
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic         cfg_index,
	input  wire logic [6:0]   cfg_data
);

	frsm_pkg::cmd_t  cmd;
	frsm_pkg::stat_t st;

	logic [13:0] out_written, out_wh, out_rh;
	logic [8:0]  out_dropped;
	logic [14:0] out_pending;
	logic [31:0] out_lost;
	logic        out_status;

	// Registers are plain flops, so take every write at once.
	assign cfg_ready = 1'b1;

	frsm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	frsm_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.st          (st),
		.cfg_valid   (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_func     (s_tuser),
		.in_slot     (s_tdata[13:0]),
		.in_bcnt     (s_tdata[29:14]),
		.in_len      (s_tdata[37:30]),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_status  (out_status),
		.out_written (out_written),
		.out_dropped (out_dropped),
		.out_pending (out_pending),
		.out_lost    (out_lost),
		.out_wh      (out_wh),
		.out_rh      (out_rh)
	);

	// Pack the result, pad the top bits to a whole byte.
	assign m_tdata = {6'd0, out_rh, out_wh, out_lost, out_pending, out_dropped, out_written};
	assign m_tuser = out_status;

	// One request in flight: ready must drop right after an accept.
	`FRSM_ASSERT_NEXT(a_one_inflight, s_tvalid && s_tready, !s_tready,
		"request accepted while another is in flight")
	// A fresh result only comes out of a busy block.
	`FRSM_ASSERT_SAME(a_result_after_work, $rose(m_tvalid), $past(!s_tready),
		"result appeared without work in progress")
	// Padding bits above the last result field stay zero.
	`FRSM_ASSERT_SAME(a_pad_zero, m_tvalid, m_tdata[103:98] == 6'd0,
		"result padding bits not zero")

endmodule
`default_nettype wire
